FILE: rtl/pwl_pkg.sv
`timescale 1ns / 1ps
// Shared constants and control/status types for the interpolation table.
package pwl_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int DATA_W      = 32;
   localparam int WIDE_W      = DATA_W + 1;
   localparam int PROD_W      = 2 * WIDE_W;
   localparam int STEP_W      = $clog2(WIDE_W + 1);
   localparam logic [STEP_W-1:0] LAST_STEP     = STEP_W'(WIDE_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(WIDE_W);

   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_QUERY = 1'b1;

   localparam logic [1:0] RANGE_INSIDE = 2'd0;
   localparam logic [1:0] RANGE_LOW    = 2'd1;
   localparam logic [1:0] RANGE_HIGH   = 2'd2;

   localparam logic [6:0] USED_RESET = 7'd2;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              rd_last;
      logic              load_query;
      logic              decide;
      logic              mul_step;
      logic              div_init;
      logic              div_step;
      logic              finish;
   } dp_cmd_type;

   typedef struct packed {
      logic interp;
   } dp_sts_type;

endpackage

FILE: rtl/pwl_datapath.sv
`timescale 1ns / 1ps
// Table memories, bracket scan, serial multiplier and serial divider.
module pwl_datapath
   import pwl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [5:0]               wr_index,
   input  logic signed [31:0]       wr_key,
   input  logic signed [31:0]       wr_value,
   input  logic signed [31:0]       query_point,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   output logic signed [31:0]       interp_value,
   output logic [1:0]               range_status
);

   logic signed [DATA_W-1:0] key_mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] val_mem [TABLE_DEPTH];

   logic signed [DATA_W-1:0] rkey_ff, rval_ff;
   logic                     rvalid_ff, rlast_ff, rfirst_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic signed [DATA_W-1:0] k0_ff, v0_ff, kl_ff, vl_ff;
   logic signed [DATA_W-1:0] pk_ff, pv_ff;
   logic                     match_ff, brk_ff;
   logic signed [DATA_W-1:0] mval_ff;
   logic signed [DATA_W-1:0] ka_ff, kb_ff, va_ff, vb_ff;
   logic [WIDE_W-1:0]        mag_ff, dist_ff, span_ff;
   logic                     neg_ff;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [WIDE_W:0]          rem_ff;
   logic [WIDE_W-1:0]        low_ff, quo_ff;
   logic [WIDE_W:0]          trial;
   logic signed [DATA_W-1:0] res_ff;
   logic [1:0]               rng_ff;
   logic signed [WIDE_W-1:0] d_ab, d_xa, d_span;

   // Write a point; read one slot per cycle during the scan
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_index[ADDR_W-1:0]] <= wr_key;
         val_mem[wr_index[ADDR_W-1:0]] <= wr_value;
      end
      if (cmd.rd_en) begin
         rkey_ff <= key_mem[cmd.rd_addr];
         rval_ff <= val_mem[cmd.rd_addr];
      end
   end

   // Track read beats
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= cmd.rd_en;
      end
      rlast_ff  <= cmd.rd_last;
      rfirst_ff <= (cmd.rd_addr == '0);
   end

   // Scan: first exact match, end points, first bracketing pair
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         x_ff     <= query_point;
         match_ff <= 1'b0;
         brk_ff   <= 1'b0;
      end else if (rvalid_ff) begin
         pk_ff <= rkey_ff;
         pv_ff <= rval_ff;
         if (rfirst_ff) begin
            k0_ff <= rkey_ff;
            v0_ff <= rval_ff;
         end
         if (rlast_ff) begin
            kl_ff <= rkey_ff;
            vl_ff <= rval_ff;
         end
         if (!match_ff && rkey_ff == x_ff) begin
            match_ff <= 1'b1;
            mval_ff  <= rval_ff;
         end
         if (!rfirst_ff && !brk_ff && (rkey_ff > x_ff || rlast_ff)) begin
            brk_ff <= 1'b1;
            ka_ff  <= pk_ff;
            kb_ff  <= rkey_ff;
            va_ff  <= pv_ff;
            vb_ff  <= rval_ff;
         end
      end
   end

   assign sts.interp = !match_ff && !(x_ff < k0_ff) && !(x_ff > kl_ff);

   assign d_ab   = WIDE_W'(vb_ff) - WIDE_W'(va_ff);
   assign d_xa   = WIDE_W'(x_ff) - WIDE_W'(ka_ff);
   assign d_span = WIDE_W'(kb_ff) - WIDE_W'(ka_ff);

   assign acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                 + (dist_ff[WIDE_W-1] ? PROD_W'(mag_ff) : '0);
   assign trial  = {rem_ff[WIDE_W-1:0], low_ff[WIDE_W-1]};

   // Decide, then multiply MSB first, then restoring divide
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         neg_ff  <= (vb_ff < va_ff);
         mag_ff  <= (vb_ff < va_ff) ? -d_ab : d_ab;
         dist_ff <= d_xa;
         span_ff <= d_span;
         acc_ff  <= '0;
         if (match_ff) begin
            res_ff <= mval_ff;
            rng_ff <= RANGE_INSIDE;
         end else if (x_ff < k0_ff) begin
            res_ff <= v0_ff;
            rng_ff <= RANGE_LOW;
         end else if (x_ff > kl_ff) begin
            res_ff <= vl_ff;
            rng_ff <= RANGE_HIGH;
         end else begin
            rng_ff <= RANGE_INSIDE;
         end
      end
      if (cmd.mul_step) begin
         acc_ff  <= acc_in;
         dist_ff <= {dist_ff[WIDE_W-2:0], 1'b0};
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, acc_ff[PROD_W-1:WIDE_W]};
         low_ff <= acc_ff[WIDE_W-1:0];
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         low_ff <= {low_ff[WIDE_W-2:0], 1'b0};
         if (trial >= {1'b0, span_ff}) begin
            rem_ff <= trial - {1'b0, span_ff};
            quo_ff <= {quo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[WIDE_W-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         res_ff <= neg_ff ? va_ff - DATA_W'(quo_ff) : va_ff + DATA_W'(quo_ff);
      end
   end

   assign interp_value = res_ff;
   assign range_status = rng_ff;

endmodule

FILE: rtl/pwl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: table scan, multiply and divide steps, result strobe.
module pwl_ctrl
   import pwl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        kind,
   input  logic [6:0]  used_entries,
   input  dp_sts_type  sts,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        done
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, last_addr;
   logic [STEP_W-1:0] step_ff, step_in;

   // Clamp the entry count to the table
   always_comb begin
      if (used_entries < 7'd2) begin
         last_addr = ADDR_W'(1);
      end else if (used_entries > 7'(TABLE_DEPTH)) begin
         last_addr = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         last_addr = ADDR_W'(used_entries - 7'd1);
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.rd_addr = addr_ff;
      cmd.rd_last = (addr_ff == last_addr);
      case (state_ff)
         ST_IDLE: begin
            if (start && kind == KIND_QUERY) begin
               cmd.load_query = 1'b1;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            step_in    = '0;
            state_in   = sts.interp ? ST_MUL : ST_OUT;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Load the divider once the product has settled, then step it
            step_in = step_ff + 1'b1;
            if (step_ff == '0) begin
               cmd.div_init = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
            if (step_ff == DIV_LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_OUT);

endmodule

FILE: rtl/piecewise_linear_table_interp_top.sv
`timescale 1ns / 1ps
// Top level: register port, sequencer and datapath of the interpolation table.
//
// Usage:
//   Command channel: drive start with the req_ fields while busy is low; the
//   beat is taken at that edge. req_kind 0 writes key/value into slot
//   req_entry_index and leaves busy low, so writes may go every cycle.
//   req_kind 1 queries at req_query_point and raises busy until the result.
//   Result channel: rsp_valid is high for one cycle with rsp_interp_value and
//   rsp_range_status (0 inside, 1 clamped low, 2 clamped high).
//   A query scans the used entries with one memory read per cycle; when
//   interpolating it goes on with 33 steps of the shift-add multiplier, a
//   divider load and 33 steps of the restoring divider. One query at a
//   time: the next query is taken in the cycle after the result.
//   used_entries sits at byte address 0 of the APB port; write it only while
//   idle. Reset clears the sequencer and sets used_entries to 2; table
//   contents are undefined until written. The receiver cannot stall.
module piecewise_linear_table_interp_top
   import pwl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [5:0]         req_entry_index,
   input  logic signed [31:0] req_entry_key,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_query_point,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_interp_value,
   output logic [1:0]         rsp_range_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [6:0]  used_ff;
   logic        wr_en;
   dp_cmd_type  cmd;
   dp_sts_type  sts;

   // Hold the entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= USED_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
         used_ff <= pwdata[6:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {25'd0, used_ff} : 32'd0;

   assign wr_en = start && !busy && req_kind == KIND_WRITE;

   pwl_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .kind         (req_kind),
      .used_entries (used_ff),
      .sts          (sts),
      .cmd          (cmd),
      .busy         (busy),
      .done         (rsp_valid)
   );

   pwl_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (wr_en),
      .wr_index     (req_entry_index),
      .wr_key       (req_entry_key),
      .wr_value     (req_entry_value),
      .query_point  (req_query_point),
      .cmd          (cmd),
      .sts          (sts),
      .interp_value (rsp_interp_value),
      .range_status (rsp_range_status)
   );

`ifndef ASSERT_OFF
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == KIND_QUERY |=> busy)
      else $error("query beat did not raise busy");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == KIND_WRITE |=> !busy)
      else $error("write beat raised busy");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_range_status != 2'd3)
      else $error("bad range status on result");
`endif

endmodule

FILE: tb/tb_piecewise_linear_table_interp_top.sv
`timescale 1ns / 1ps
// Testbench for the piecewise-linear interpolation table: directed and random beats.
module tb_piecewise_linear_table_interp_top
   import pwl_pkg::*;
();

   localparam logic [2:0] USED_ENTRIES_ADDR = 3'd0;
   localparam int         STALL_LIMIT       = 4000;
   localparam int         DRAIN_CYCLES      = 160;
   localparam int         ITEM_BUDGET       = 1150;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
   } interp_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = KIND_WRITE;
   logic [5:0]         req_entry_index = '0;
   logic signed [31:0] req_entry_key = '0;
   logic signed [31:0] req_entry_value = '0;
   logic signed [31:0] req_query_point = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_interp_value;
   logic [1:0]         rsp_range_status;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // shadow copy of the table and the entry count register
   logic signed [31:0] key_shadow [TABLE_DEPTH];
   logic signed [31:0] value_shadow [TABLE_DEPTH];
   logic [6:0]         used_shadow = USED_RESET;

   interp_result_type  pending_results [$];
   bit                 failed = 1'b0;
   bit                 idle_enabled = 1'b1;
   int                 items_sent = 0;
   int                 stall_cycles = 0;

   piecewise_linear_table_interp_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_entries();
      if (used_shadow < 2) return 2;
      if (used_shadow > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(used_shadow);
   endfunction

   // interpolate at x over the shadow table
   function automatic interp_result_type interpolate(input logic signed [31:0] x);
      interp_result_type  r;
      int                 n, i;
      longint             ka, kb, va, vb, res;
      longint unsigned    mag, x_off, span, q;
      bit                 neg;
      n = active_entries();
      for (i = 0; i < n; i++) begin
         if (key_shadow[i] == x) begin
            r.value = value_shadow[i];
            r.status = RANGE_INSIDE;
            return r;
         end
      end
      if (x < key_shadow[0]) begin
         r.value = value_shadow[0];
         r.status = RANGE_LOW;
         return r;
      end
      if (x > key_shadow[n-1]) begin
         r.value = value_shadow[n-1];
         r.status = RANGE_HIGH;
         return r;
      end
      for (i = 1; i + 1 < n; i++)
         if (key_shadow[i] > x) break;
      ka = key_shadow[i-1];
      kb = key_shadow[i];
      va = value_shadow[i-1];
      vb = value_shadow[i];
      neg = vb < va;
      mag = neg ? longint'(va - vb) : longint'(vb - va);
      x_off = longint'(longint'(x) - ka);
      span = longint'(kb - ka);
      q = (span != 0) ? (mag * x_off) / span : 0;
      res = neg ? va - longint'(q) : va + longint'(q);
      r.value = res[31:0];
      r.status = RANGE_INSIDE;
      return r;
   endfunction

   // present one beat and hold it until taken; predict on acceptance
   task automatic send_beat(input logic kind, input logic [5:0] idx,
                            input logic signed [31:0] key, input logic signed [31:0] val,
                            input logic signed [31:0] point);
      if (idle_enabled && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_entry_index <= idx;
      req_entry_key <= key;
      req_entry_value <= val;
      req_query_point <= point;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_WRITE) begin
         key_shadow[idx] = key;
         value_shadow[idx] = val;
      end else begin
         pending_results.push_back(interpolate(point));
      end
      items_sent++;
   endtask

   task automatic write_point(input int idx, input logic signed [31:0] key,
                              input logic signed [31:0] val);
      send_beat(KIND_WRITE, idx[5:0], key, val, $urandom());
   endtask

   task automatic query_at(input logic signed [31:0] point);
      send_beat(KIND_QUERY, 6'($urandom()), $urandom(), $urandom(), point);
   endtask

   // wait out all results, then write the entry count and read it back
   task automatic set_used_entries(input logic [6:0] count);
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= USED_ENTRIES_ADDR;
      pwdata <= {$urandom_range(0, 1) ? 25'h1FF_FFFF : 25'h0, count};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      used_shadow = count;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[6:0] !== count) begin
         $display("%0t used_entries readback: expected %0d actual %0d",
                  $time, count, prdata[6:0]);
         failed = 1'b1;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // load slots 0..n-1 with strictly rising keys and random values
   task automatic load_rising_table(input int n, input bit tight);
      longint offset, max_step, k;
      int     i;
      offset = longint'($urandom()) / 2;
      max_step = (64'sd4294967295 - offset) / TABLE_DEPTH;
      k = -64'sd2147483648 + offset;
      for (i = 0; i < n; i++) begin
         write_point(i, k[31:0], $urandom());
         k += tight ? $urandom_range(1, 4) : $urandom_range(1, int'(max_step));
      end
   endtask

   // query somewhere useful: between neighbors, on a key, or anywhere
   task automatic query_shaped();
      int     n, i, pick;
      longint ka, kb;
      n = active_entries();
      pick = $urandom_range(0, 99);
      i = $urandom_range(0, n - 2);
      ka = key_shadow[i];
      kb = key_shadow[i+1];
      if (pick < 60 && kb > ka)
         query_at(32'(ka + longint'($urandom_range(0, int'((kb - ka) > 64'h7FFF_FFFF ?
                                                        64'h7FFF_FFFF : kb - ka)))));
      else if (pick < 80)
         query_at(key_shadow[$urandom_range(0, n - 1)]);
      else
         query_at($urandom());
   endtask

   task automatic test_directed();
      int i;
      for (i = 0; i < TABLE_DEPTH; i++)
         write_point(i, i * 32'sh0001_0000 - 32'sh0010_0000, i * 32'sh0003_0000);
      set_used_entries(7'd64);
      query_at(-32'sh0010_0000);
      query_at(32'sh0000_0000);
      query_at(32'sh002F_0000);
      query_at(32'sh0000_8000);
      query_at(32'sh8000_0000);
      query_at(32'sh7FFF_FFFF);
      // widest span, full-scale falling values
      write_point(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
      write_point(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
      set_used_entries(7'd2);
      query_at(32'sh0000_0000);
      query_at(32'sh8000_0001);
      query_at(32'sh7FFF_FFFE);
      query_at(32'sh7FFF_FFFF);
      // keys out of order, and the top slot
      write_point(2, 32'sh0000_0000, 32'sh0000_1234);
      write_point(63, 32'sh1234_5678, 32'shFEDC_BA98);
      set_used_entries(7'd3);
      query_at(32'sh0000_0000);
      query_at(32'sh0000_0001);
      query_at(32'shFFFF_FFFF);
      // entry count below two and above the table
      set_used_entries(7'd0);
      query_at(32'sh0000_0000);
      set_used_entries(7'd127);
      query_at(32'sh1234_5678);
   endtask

   task automatic test_random();
      int          n, k;
      logic [6:0]  count;
      while (items_sent < ITEM_BUDGET) begin
         case ($urandom_range(0, 7))
            0: count = 7'd2;
            1: count = 7'd64;
            2: count = 7'($urandom_range(0, 1));
            3: count = 7'($urandom_range(65, 127));
            default: count = 7'($urandom_range(2, 12));
         endcase
         if (count == 7'd64 || count > 7'd64) count = $urandom_range(0, 3) == 0 ? count : 7'd8;
         set_used_entries(count);
         n = active_entries();
         // one stretch with no idling
         idle_enabled = !(items_sent > ITEM_BUDGET / 3 && items_sent < ITEM_BUDGET / 2);
         load_rising_table(n, $urandom_range(0, 5) == 0);
         for (k = 0; k < 20; k++) begin
            if ($urandom_range(0, 9) == 0)
               write_point($urandom_range(0, TABLE_DEPTH - 1), $urandom(), $urandom());
            else
               query_shaped();
         end
      end
      start <= 1'b0;
   endtask

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      interp_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: value %h status %0d",
                     $time, rsp_interp_value, rsp_range_status);
            failed = 1'b1;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_interp_value !== exp_r.value) begin
               $display("%0t interp_value: expected %h actual %h",
                        $time, exp_r.value, rsp_interp_value);
               failed = 1'b1;
            end
            if (rsp_range_status !== exp_r.status) begin
               $display("%0t range_status: expected %0d actual %0d",
                        $time, exp_r.status, rsp_range_status);
               failed = 1'b1;
            end
         end
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
rtl/pwl_pkg.sv
rtl/pwl_datapath.sv
rtl/pwl_ctrl.sv
rtl/piecewise_linear_table_interp_top.sv
tb/tb_piecewise_linear_table_interp_top.sv
